[hdl/knn_top10_distance_scan_macros.svh]
`ifndef KNN_TOP10_DISTANCE_SCAN_MACROS_SVH
`define KNN_TOP10_DISTANCE_SCAN_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define KNN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("knn scan check failed");

// Checks that a condition holds in the cycle after its trigger.
`define KNN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("knn scan check failed");

`endif

[hdl/knn_pkg.sv]
`timescale 1ns / 1ps

package knn_pkg;

  localparam int DistW   = 24;
  localparam int CandIdW = 20;
  localparam int NidW    = 21;
  localparam int RankW   = 4;
  localparam int ElemW   = 8;

  typedef logic [DistW-1:0]   dist_t;
  typedef logic [CandIdW-1:0] cand_id_t;
  typedef logic [RankW-1:0]   rank_t;

  // An empty slot holds the all-ones distance.
  localparam dist_t DIST_MAX = {DistW{1'b1}};

  // Request codes.
  localparam logic REQ_ELEM = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  acc;   // accumulate one element pair
    logic  fin;   // the pair closes its candidate
    logic  clr;   // drop the running sum
    logic  ins;   // insert the finished candidate into the list
    logic  emit;  // load the head slot into the output register and shift
    rank_t rank;
    logic  last;
  } knn_cmd_t;

endpackage

[hdl/knn_dp.sv]
`timescale 1ns / 1ps

module knn_dp #(
  parameter int TOP_K = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  knn_pkg::knn_cmd_t              cmd,
  input  logic [knn_pkg::ElemW-1:0]      in_query_elem,
  input  logic [knn_pkg::ElemW-1:0]      in_base_elem,
  input  knn_pkg::cand_id_t              in_cand_id,
  output knn_pkg::rank_t                 out_rank,
  output logic signed [knn_pkg::NidW-1:0] out_neighbor_id,
  output knn_pkg::dist_t                 out_distance,
  output logic                           out_list_last
);

  knn_pkg::dist_t    accum_r;
  knn_pkg::dist_t    fin_dist_r;
  knn_pkg::cand_id_t fin_id_r;
  knn_pkg::dist_t    dist_r [TOP_K];
  knn_pkg::cand_id_t id_r   [TOP_K];
  logic [TOP_K-1:0]  lt;

  logic [knn_pkg::ElemW-1:0]     diff;
  logic [2*knn_pkg::ElemW-1:0]   term;
  logic [knn_pkg::DistW:0]       sum;
  knn_pkg::dist_t                sat;

  knn_pkg::rank_t                   out_rank_r;
  logic signed [knn_pkg::NidW-1:0]  out_neighbor_id_r;
  knn_pkg::dist_t                   out_distance_r;
  logic                             out_list_last_r;

  // Squared difference and saturating running sum.
  assign diff = (in_query_elem >= in_base_elem) ? in_query_elem - in_base_elem
                                                : in_base_elem - in_query_elem;
  assign term = diff * diff;
  assign sum  = {1'b0, accum_r} + (knn_pkg::DistW + 1)'(term);
  assign sat  = sum[knn_pkg::DistW] ? knn_pkg::DIST_MAX : sum[knn_pkg::DistW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
    end else if (cmd.clr) begin
      accum_r <= '0;
    end else if (cmd.acc) begin
      accum_r <= cmd.fin ? '0 : sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && cmd.fin) begin
      fin_dist_r <= sat;
      fin_id_r   <= in_cand_id;
    end
  end

  // Each slot either takes the candidate, takes its upper neighbor during an
  // insert, or takes its lower neighbor while the list drains.
  for (genvar g = 0; g < TOP_K; g++) begin : g_slot
    knn_pkg::dist_t    ins_dist;
    knn_pkg::cand_id_t ins_id;
    knn_pkg::dist_t    sh_dist;
    knn_pkg::cand_id_t sh_id;

    assign lt[g] = fin_dist_r < dist_r[g];

    if (g == 0) begin : g_head
      assign ins_dist = fin_dist_r;
      assign ins_id   = fin_id_r;
    end else begin : g_body
      assign ins_dist = lt[g-1] ? dist_r[g-1] : fin_dist_r;
      assign ins_id   = lt[g-1] ? id_r[g-1]   : fin_id_r;
    end

    if (g == TOP_K - 1) begin : g_tail
      assign sh_dist = knn_pkg::DIST_MAX;
      assign sh_id   = id_r[g];
    end else begin : g_mid
      assign sh_dist = dist_r[g+1];
      assign sh_id   = id_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dist_r[g] <= knn_pkg::DIST_MAX;
      end else if (cmd.ins && lt[g]) begin
        dist_r[g] <= ins_dist;
      end else if (cmd.emit) begin
        dist_r[g] <= sh_dist;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.ins && lt[g]) begin
        id_r[g] <= ins_id;
      end else if (cmd.emit) begin
        id_r[g] <= sh_id;
      end
    end
  end

  // A slot is empty exactly when it holds the all-ones distance.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rank_r      <= cmd.rank;
      out_list_last_r <= cmd.last;
      out_distance_r  <= dist_r[0];
      out_neighbor_id_r <= (dist_r[0] == knn_pkg::DIST_MAX) ? '1
                                                             : $signed({1'b0, id_r[0]});
    end
  end

  assign out_rank        = out_rank_r;
  assign out_neighbor_id = out_neighbor_id_r;
  assign out_distance    = out_distance_r;
  assign out_list_last   = out_list_last_r;

endmodule

[hdl/knn_ctrl.sv]
`timescale 1ns / 1ps

module knn_ctrl #(
  parameter int TOP_K = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  input  logic              in_elem_last,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output knn_pkg::knn_cmd_t cmd
);

  localparam int CntW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(TOP_K - 1);

  localparam logic [1:0] S_RUN    = 2'd0;
  localparam logic [1:0] S_INSERT = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            out_free;

  assign accept   = in_valid && (state_r == S_RUN);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_RUN: begin
        if (accept) begin
          if (in_req_type == knn_pkg::REQ_END) begin
            cmd.clr   = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_EMIT;
          end else begin
            cmd.acc = 1'b1;
            cmd.fin = in_elem_last;
            if (in_elem_last) begin
              state_nxt = S_INSERT;
            end
          end
        end
      end
      S_INSERT: begin
        cmd.ins   = 1'b1;
        state_nxt = S_RUN;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.rank = knn_pkg::rank_t'(cnt_r);
          cmd.last = (cnt_r == LastCnt);
          if (cnt_r == LastCnt) begin
            state_nxt = S_RUN;
          end else begin
            cnt_nxt = CntW'(cnt_r + 1'b1);
          end
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
    out_valid_nxt = cmd.emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_RUN);
  assign out_valid = out_valid_r;

endmodule

[hdl/knn_top10_distance_scan.sv]
`timescale 1ns / 1ps
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+--------------------------------------------
// in_       | input     | in_valid / in_stall | req_type, query_elem, base_elem, cand_id,
//           |           |                     | elem_last
// out_      | output    | out_valid/out_stall | rank, neighbor_id, distance, list_last
//
// Each element pair is accepted in the run state; the pair that closes a candidate
// is followed by the insert state, in which the ten-slot list does its parallel insert.
// An end-of-query item sends the controller to the drain, which emits TOP_K ranks as
// the list drains one slot per cycle through the output register while out_stall is low.
// Reset (rst_n low, synchronous) empties the list and clears the running sum.
// The input stalls while an insert or a drain is in progress; out_stall only holds
// the output register and the drain.

module knn_top10_distance_scan #(
  parameter int TOP_K = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [knn_pkg::ElemW-1:0]       in_query_elem,
  input  logic [knn_pkg::ElemW-1:0]       in_base_elem,
  input  knn_pkg::cand_id_t               in_cand_id,
  input  logic                            in_elem_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output knn_pkg::rank_t                  out_rank,
  output logic signed [knn_pkg::NidW-1:0] out_neighbor_id,
  output knn_pkg::dist_t                  out_distance,
  output logic                            out_list_last
);

  // The controller sequences transfers and issues one command word per cycle;
  // the datapath holds the running sum, the sorted list and the output register.
  knn_pkg::knn_cmd_t cmd;

  knn_ctrl #(
    .TOP_K(TOP_K)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_elem_last(in_elem_last),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd)
  );

  // The list is kept sorted with ties going to the earlier candidate, so a drain
  // always reads the head slot and shifting TOP_K times leaves the list empty.
  knn_dp #(
    .TOP_K(TOP_K)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_query_elem  (in_query_elem),
    .in_base_elem   (in_base_elem),
    .in_cand_id     (in_cand_id),
    .out_rank       (out_rank),
    .out_neighbor_id(out_neighbor_id),
    .out_distance   (out_distance),
    .out_list_last  (out_list_last)
  );

endmodule

[hdl/knn_chk.sv]
`timescale 1ns / 1ps
`include "knn_top10_distance_scan_macros.svh"

module knn_chk #(
  parameter int TOP_K = 10
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            in_req_type,
  input logic [knn_pkg::ElemW-1:0]       in_query_elem,
  input logic [knn_pkg::ElemW-1:0]       in_base_elem,
  input knn_pkg::cand_id_t               in_cand_id,
  input logic                            in_elem_last,
  input logic                            out_valid,
  input logic                            out_stall,
  input knn_pkg::rank_t                  out_rank,
  input logic signed [knn_pkg::NidW-1:0] out_neighbor_id,
  input knn_pkg::dist_t                  out_distance,
  input logic                            out_list_last
);

  // A stalled result keeps its payload.
  `KNN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_distance) && $stable(out_neighbor_id) && $stable(out_rank))

  // The final result of a list carries the highest rank.
  `KNN_ASSERT_NOW(a_last_rank, out_valid && out_list_last, out_rank == knn_pkg::rank_t'(TOP_K - 1))

  // An empty slot shows both markers together.
  `KNN_ASSERT_NOW(a_empty_pair, out_valid && (out_distance == knn_pkg::DIST_MAX), out_neighbor_id == '1)

  // Within a list, ranks count up and distances never fall.
  `KNN_ASSERT_NEXT(a_rank_step, out_valid && !out_stall && !out_list_last, !out_valid || (out_rank == knn_pkg::rank_t'($past(out_rank) + 1'b1)))
  `KNN_ASSERT_NEXT(a_sorted, out_valid && !out_stall && !out_list_last, !out_valid || (out_distance >= $past(out_distance)))

endmodule

bind knn_top10_distance_scan knn_chk #(.TOP_K(TOP_K)) u_knn_chk (.*);

[sim/knn_top10_distance_scan_test.sv]
`timescale 1ns / 1ps

module knn_top10_distance_scan_test;
  import knn_pkg::*;

  // The block keeps the ten nearest candidates; every end of query drains them all.
  localparam int TOP_K = 10;
  // Generous cycle budget; a correct run stays well inside it.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Random part: roughly this many element and end-of-query transfers.
  localparam int RANDOM_ITEMS = 100;
  // Long receiver hold-off, long enough for the drain to back up into the input.
  localparam int HOLD_OFF_CYCLES = 120;
  // A candidate of this many (255 - 0)^2 terms lands just below saturation,
  // and one more term pushes the running sum past the all-ones marker.
  localparam int NEAR_FULL_TERMS = 258;

  localparam logic signed [NidW-1:0] EMPTY_ID = '1;

  // One input transfer, field for field as the ports carry it.
  typedef struct packed {
    logic             req_type;
    logic [ElemW-1:0] query_elem;
    logic [ElemW-1:0] base_elem;
    cand_id_t         cand_id;
    logic             elem_last;
  } scan_item_t;

  // One result transfer: a single rank of the sorted neighbor list.
  typedef struct packed {
    rank_t                   rank;
    logic signed [NidW-1:0]  neighbor_id;
    dist_t                   distance;
    logic                    list_last;
  } neighbor_t;

  // A row of the opening stimulus. When typed is set the row is an end of
  // query whose list holds at most one entry, so the expected drain is
  // written out here: head_id and head_dist at rank 0, empty slots after it.
  typedef struct packed {
    logic                    req_type;
    logic [ElemW-1:0]        query_elem;
    logic [ElemW-1:0]        base_elem;
    cand_id_t                cand_id;
    logic                    elem_last;
    logic                    typed;
    logic signed [NidW-1:0]  head_id;
    dist_t                   head_dist;
  } opening_row_t;

  localparam int OPENING_ROWS = 19;
  localparam opening_row_t OPENING[OPENING_ROWS] = '{
    // End of query straight out of reset: the list must be completely empty.
    // Its element fields sit at their extremes and must be ignored.
    '{REQ_END,  8'd255, 8'd255, 20'hFFFFF, 1'b1, 1'b1, EMPTY_ID, DIST_MAX},
    // Largest single term with the largest id.
    '{REQ_ELEM, 8'd255, 8'd0,   20'hFFFFF, 1'b1, 1'b0, EMPTY_ID, DIST_MAX},
    '{REQ_END,  8'd0,   8'd0,   20'h00000, 1'b0, 1'b1, 21'sh0FFFFF, 24'd65025},
    // A partial candidate is dropped by the end of query.
    '{REQ_ELEM, 8'd0,   8'd255, 20'h00000, 1'b0, 1'b0, EMPTY_ID, DIST_MAX},
    '{REQ_END,  8'd0,   8'd0,   20'h00000, 1'b0, 1'b1, EMPTY_ID, DIST_MAX},
    // Its running sum must not leak into the next candidate.
    '{REQ_ELEM, 8'd3,   8'd7,   20'h00005, 1'b1, 1'b0, EMPTY_ID, DIST_MAX},
    '{REQ_END,  8'd0,   8'd0,   20'h00000, 1'b0, 1'b1, 21'sh000005, 24'd16},
    // Zero distances tie; the earlier candidate keeps the better rank.
    '{REQ_ELEM, 8'd0,   8'd255, 20'h00000, 1'b1, 1'b0, EMPTY_ID, DIST_MAX},
    '{REQ_ELEM, 8'd0,   8'd0,   20'h00001, 1'b1, 1'b0, EMPTY_ID, DIST_MAX},
    '{REQ_ELEM, 8'd255, 8'd255, 20'h00002, 1'b1, 1'b0, EMPTY_ID, DIST_MAX},
    // A three-element candidate, differences of both signs.
    '{REQ_ELEM, 8'd10,  8'd20,  20'h00003, 1'b0, 1'b0, EMPTY_ID, DIST_MAX},
    '{REQ_ELEM, 8'd20,  8'd10,  20'h00003, 1'b0, 1'b0, EMPTY_ID, DIST_MAX},
    '{REQ_ELEM, 8'd1,   8'd0,   20'h00003, 1'b1, 1'b0, EMPTY_ID, DIST_MAX},
    // Alternating id bit patterns, tied at distance one.
    '{REQ_ELEM, 8'd128, 8'd127, 20'hAAAAA, 1'b1, 1'b0, EMPTY_ID, DIST_MAX},
    '{REQ_ELEM, 8'd127, 8'd128, 20'h55555, 1'b1, 1'b0, EMPTY_ID, DIST_MAX},
    '{REQ_END,  8'd85,  8'd170, 20'h12345, 1'b0, 1'b0, EMPTY_ID, DIST_MAX},
    '{REQ_ELEM, 8'd200, 8'd100, 20'h80000, 1'b0, 1'b0, EMPTY_ID, DIST_MAX},
    '{REQ_ELEM, 8'd255, 8'd0,   20'h80000, 1'b1, 1'b0, EMPTY_ID, DIST_MAX},
    '{REQ_END,  8'd170, 8'd85,  20'h54321, 1'b1, 1'b0, EMPTY_ID, DIST_MAX}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_req_type = REQ_ELEM;
  logic [ElemW-1:0] in_query_elem = '0;
  logic [ElemW-1:0] in_base_elem = '0;
  cand_id_t         in_cand_id = '0;
  logic             in_elem_last = 1'b0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  rank_t                  out_rank;
  logic signed [NidW-1:0] out_neighbor_id;
  dist_t                  out_distance;
  logic                   out_list_last;

  // Our own copy of the block's state: the running sum of the candidate being
  // scanned and the sorted list, best first.
  dist_t                  running_dist;
  dist_t                  ranked_dist[TOP_K];
  logic signed [NidW-1:0] ranked_id[TOP_K];

  // Ranks that the block still owes us, oldest first.
  neighbor_t pending_neighbors[$];

  int          error_count = 0;
  int unsigned cycle_count = 0;

  // The sender asks for a long hold-off; the receiver flags it while it lasts.
  bit hold_off_req = 1'b0;
  bit hold_off_active = 1'b0;

  knn_top10_distance_scan #(
    .TOP_K(TOP_K)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_query_elem  (in_query_elem),
    .in_base_elem   (in_base_elem),
    .in_cand_id     (in_cand_id),
    .in_elem_last   (in_elem_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rank       (out_rank),
    .out_neighbor_id(out_neighbor_id),
    .out_distance   (out_distance),
    .out_list_last  (out_list_last)
  );

  always #4 clk = ~clk;

  function automatic void empty_neighbor_list();
    for (int r = 0; r < TOP_K; r++) begin
      ranked_dist[r] = DIST_MAX;
      ranked_id[r] = EMPTY_ID;
    end
  endfunction

  // Applies one accepted transfer to the local state. An end of query queues
  // the whole list as expected ranks unless the caller supplies them itself.
  function automatic void scan_neighbors(scan_item_t it, bit queue_ranks);
    logic [ElemW-1:0] diff;
    logic [DistW:0]   total;
    neighbor_t        entry;
    int               p;
    if (it.req_type == REQ_END) begin
      if (queue_ranks) begin
        for (int r = 0; r < TOP_K; r++) begin
          entry.rank = rank_t'(r);
          entry.neighbor_id = ranked_id[r];
          entry.distance = ranked_dist[r];
          entry.list_last = (r == TOP_K - 1);
          pending_neighbors.push_back(entry);
        end
      end
      empty_neighbor_list();
      running_dist = '0;
    end else begin
      diff = (it.query_elem >= it.base_elem) ? it.query_elem - it.base_elem
                                             : it.base_elem - it.query_elem;
      total = running_dist + diff * diff;
      running_dist = (total > DIST_MAX) ? DIST_MAX : total[DistW-1:0];
      if (it.elem_last) begin
        // Strict less-than: a saturated candidate never beats an empty slot,
        // and a tie leaves the earlier candidate ahead.
        if (running_dist < ranked_dist[TOP_K-1]) begin
          p = TOP_K - 1;
          while (p > 0 && running_dist < ranked_dist[p-1]) begin
            ranked_dist[p] = ranked_dist[p-1];
            ranked_id[p] = ranked_id[p-1];
            p--;
          end
          ranked_dist[p] = running_dist;
          ranked_id[p] = {1'b0, it.cand_id};
        end
        running_dist = '0;
      end
    end
  endfunction

  // Mostly back-to-back, sometimes a short gap, now and then a long one.
  function automatic int sender_gap(bit calm);
    int r;
    r = $urandom_range(0, 9);
    if (calm || r < 6) begin
      return 0;
    end
    if (r < 9) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 20);
  endfunction

  // Element values: full range, a narrow band that makes ties likely, or the extremes.
  function automatic logic [ElemW-1:0] pick_elem(int flavor);
    case (flavor)
      0: return ElemW'($urandom_range(0, 255));
      1: return ElemW'($urandom_range(0, 3));
      default: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    endcase
  endfunction

  // Offers one item and returns at the edge that takes it. The payload changes
  // only here and the valid drops only between items, so a stalled transfer stays put.
  task automatic offer_item(scan_item_t it, int gap, bit queue_ranks);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= it.req_type;
    in_query_elem <= it.query_elem;
    in_base_elem <= it.base_elem;
    in_cand_id <= it.cand_id;
    in_elem_last <= it.elem_last;
    do @(posedge clk); while (in_stall);
    scan_neighbors(it, queue_ranks);
  endtask

  // Drops the valid and waits until every owed rank has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_neighbors.size() != 0);
  endtask

  // One well-formed candidate of the given length with random content.
  task automatic offer_candidate(int dim, int flavor, bit calm);
    scan_item_t it;
    it.req_type = REQ_ELEM;
    it.cand_id = cand_id_t'($urandom_range(0, 20'hFFFFF));
    for (int e = 0; e < dim; e++) begin
      it.query_elem = pick_elem(flavor);
      it.base_elem = pick_elem(flavor);
      it.elem_last = (e == dim - 1);
      offer_item(it, sender_gap(calm), 1'b1);
    end
  endtask

  function automatic scan_item_t end_of_query();
    scan_item_t it;
    it.req_type = REQ_END;
    it.query_elem = pick_elem(0);
    it.base_elem = pick_elem(0);
    it.cand_id = cand_id_t'($urandom_range(0, 20'hFFFFF));
    it.elem_last = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Output side. Each pass through the loop holds one stall level for a
  // stretch of cycles, so out_stall gets one assignment per edge at most.
  initial begin : receiver
    int pick;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        // Hold the output long enough for the drain to block and the input
        // to back up behind it while the sender keeps offering.
        hold_off_active = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_active = 1'b0;
        hold_off_req = 1'b0;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else if (pick < 8) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (pick < 9) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(8, 30)) @(posedge clk);
        end else begin
          // A stretch with the receiver always ready.
          out_stall <= 1'b0;
          repeat ($urandom_range(20, 50)) @(posedge clk);
        end
      end
    end
  end

  // Every result transfer is matched against the oldest owed rank. Signals
  // are read right after the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    neighbor_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_neighbors.size() == 0) begin
        $error("unexpected result: rank %0d id %0d distance %0d",
               out_rank, out_neighbor_id, out_distance);
        error_count++;
      end else begin
        want = pending_neighbors.pop_front();
        if (out_rank !== want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, out_rank);
          error_count++;
        end
        if (out_neighbor_id !== want.neighbor_id) begin
          $error("neighbor_id: expected %0d, got %0d", want.neighbor_id, out_neighbor_id);
          error_count++;
        end
        if (out_distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, out_distance);
          error_count++;
        end
        if (out_list_last !== want.list_last) begin
          $error("list_last: expected %0d, got %0d", want.list_last, out_list_last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    scan_item_t   it;
    neighbor_t    entry;
    opening_row_t row;
    int           sent;
    int           num_cands;
    int           dim;
    int           flavor;
    bit           calm;

    empty_neighbor_list();
    running_dist = '0;

    // Synchronous reset, held from time zero and never asserted again.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening rows: extremes, ties, dropped partial candidates, empty lists.
    for (int i = 0; i < OPENING_ROWS; i++) begin
      row = OPENING[i];
      it.req_type = row.req_type;
      it.query_elem = row.query_elem;
      it.base_elem = row.base_elem;
      it.cand_id = row.cand_id;
      it.elem_last = row.elem_last;
      offer_item(it, sender_gap(1'b0), !row.typed);
      if (row.typed) begin
        for (int r = 0; r < TOP_K; r++) begin
          entry.rank = rank_t'(r);
          entry.neighbor_id = (r == 0) ? row.head_id : EMPTY_ID;
          entry.distance = (r == 0) ? row.head_dist : DIST_MAX;
          entry.list_last = (r == TOP_K - 1);
          pending_neighbors.push_back(entry);
        end
      end
    end

    // Saturation: one candidate just long enough to run the sum past the
    // all-ones marker. It must stick there and stay out of the list; a sum
    // that wrapped instead would show up as a small distance.
    it.req_type = REQ_ELEM;
    it.query_elem = 8'd255;
    it.base_elem = 8'd0;
    it.cand_id = cand_id_t'($urandom_range(0, 20'hFFFFF));
    for (int e = 0; e < NEAR_FULL_TERMS + 1; e++) begin
      it.elem_last = (e == NEAR_FULL_TERMS);
      offer_item(it, sender_gap(1'b1), 1'b1);
    end
    offer_item(end_of_query(), 0, 1'b1);

    // The sender waits here for the list to come back completely.
    drain_results();

    // Long output hold-off while the sender keeps going: queries pile up
    // behind a blocked drain and the input has to stall.
    hold_off_req = 1'b1;
    in_valid <= 1'b0;
    do @(posedge clk); while (!hold_off_active);
    for (int qn = 0; qn < 3; qn++) begin
      for (int c = 0; c < 4; c++) begin
        offer_candidate($urandom_range(1, 3), 0, 1'b1);
      end
      offer_item(end_of_query(), 0, 1'b1);
    end

    // Random queries. Most are well formed: a handful of candidates, each
    // closed by its last element, then an end of query. Some break off in the
    // middle of a candidate so the partial sum must be dropped.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      num_cands = $urandom_range(0, 14);
      for (int c = 0; c < num_cands; c++) begin
        dim = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        flavor = $urandom_range(0, 2);
        offer_candidate(dim, flavor, calm);
        sent += dim;
      end
      if ($urandom_range(0, 5) == 0) begin
        it.req_type = REQ_ELEM;
        it.query_elem = pick_elem(0);
        it.base_elem = pick_elem(0);
        it.cand_id = cand_id_t'($urandom_range(0, 20'hFFFFF));
        it.elem_last = 1'b0;
        offer_item(it, sender_gap(calm), 1'b1);
        sent++;
      end
      offer_item(end_of_query(), sender_gap(calm), 1'b1);
      sent++;
    end

    // Wait for the last ranks, then give the block a short while to show
    // anything it should not send.
    drain_results();
    repeat (2 * TOP_K + 4) @(posedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
